// ===== hdl/lfd_pkg.sv =====
// Package for the laser frame decoder: frame geometry, marker bytes,
// sequencer state and shared adder request types. No dependencies.
package lfd_pkg;

    localparam int FRAME_LENGTH = 22;
    localparam int ADDR_W       = 5;
    localparam int ACC_W        = 26;   // ten shifted 16-bit words fit in 26 bits
    localparam int SUM_W        = 15;

    localparam logic [7:0] START_MARK = 8'hFA;
    localparam logic [7:0] INDEX_BIAS = 8'hA0;
    localparam logic [7:0] INDEX_LAST = 8'hF9;   // bias plus 89

    localparam logic [ADDR_W-1:0] CHECK_BASE = ADDR_W'(20);
    localparam logic [ADDR_W-1:0] CHECK_HI   = ADDR_W'(21);
    localparam logic [ADDR_W-1:0] INDEX_POS  = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] DATA_BASE  = ADDR_W'(4);
    localparam logic [ADDR_W-1:0] FULL_COUNT = ADDR_W'(FRAME_LENGTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FOLD,
        ST_VERIFY,
        ST_LOAD,
        ST_OUT,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        ALU_ACC_LO,
        ALU_ACC_HI,
        ALU_FOLD
    } t_alu_op;

    typedef struct packed {
        t_alu_op          op;
        logic [ACC_W-1:0] acc;
        logic [7:0]       data;
    } t_alu_req;

endpackage

// ===== hdl/lfd_in_if.sv =====
// Input byte channel of the laser frame decoder: valid/ready plus one
// received byte. No dependencies.
interface lfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source(output valid, output rx_byte, input ready);
    modport sink(input valid, input rx_byte, output ready);
endinterface

// ===== hdl/lfd_out_if.sv =====
// Reading channel of the laser frame decoder: valid/ready plus one
// decoded reading. No dependencies.
interface lfd_out_if;
    logic        valid;
    logic        ready;
    logic [8:0]  angle_deg;
    logic [13:0] range_mm;
    logic [15:0] strength;
    logic        reading_ok;
    logic        scan_begin;
    logic        last_reading;

    modport source(output valid, output angle_deg, output range_mm, output strength,
                   output reading_ok, output scan_begin, output last_reading,
                   input ready);
    modport sink(input valid, input angle_deg, input range_mm, input strength,
                 input reading_ok, input scan_begin, input last_reading,
                 output ready);
endinterface

// ===== hdl/lfd_alu.sv =====
// Shared shift-and-add unit for the checksum fold.
// Depends on lfd_pkg for the request struct and widths.
module lfd_alu (
    input  lfd_pkg::t_alu_req               i_req,
    output logic [lfd_pkg::ACC_W-1:0]       o_sum
);
    import lfd_pkg::*;

    localparam int HI_PAD   = ACC_W - 16;
    localparam int LO_PAD   = ACC_W - 8;
    localparam int FOLD_PAD = ACC_W - SUM_W;

    logic [ACC_W-1:0] w_a;
    logic [ACC_W-1:0] w_b;

    always_comb begin
        case (i_req.op)
            ALU_ACC_LO: begin
                // start a new word: double the running sum, add the low byte
                w_a = {i_req.acc[ACC_W-2:0], 1'b0};
                w_b = {{LO_PAD{1'b0}}, i_req.data};
            end
            ALU_ACC_HI: begin
                w_a = i_req.acc;
                w_b = {{HI_PAD{1'b0}}, i_req.data, 8'h00};
            end
            ALU_FOLD: begin
                w_a = {{FOLD_PAD{1'b0}}, i_req.acc[SUM_W-1:0]};
                w_b = {{SUM_W{1'b0}}, i_req.acc[ACC_W-1:SUM_W]};
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    assign o_sum = w_a + w_b;

endmodule

// ===== hdl/lidar_frame_decoder.sv =====
// Sequence: an ordinary byte is taken while idle. A start byte that closes a
// full 22-byte frame starts the checksum work (each stored byte in turn through
// the single read port of the frame store, then fold, then verify), then each
// reading (four byte reads, then an offer that waits while the sink stalls),
// then storing the start byte. A rejected frame skips the readings. The shared
// adder does the checksum sums. Reset (synchronous, active low) empties the
// frame; store contents stay.
module lidar_frame_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lfd_in_if.sink     i_in,
    lfd_out_if.source  o_out
);
    import lfd_pkg::*;

    localparam int IDX_W = 7;

    logic [7:0]        mem [FRAME_LENGTH];
    logic [7:0]        r_rd_data;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_fill, n_fill;
    logic [ADDR_W-1:0] r_pos, n_pos;
    logic              r_half, n_half;
    logic [1:0]        r_reading, n_reading;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [7:0]        r_idx_byte, n_idx_byte;
    logic [15:0]       r_chk, n_chk;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [7:0]        r_b0, n_b0;
    logic [7:0]        r_b1, n_b1;
    logic [15:0]       r_q, n_q;
    logic [7:0]        r_pending, n_pending;

    logic              w_in_acc;
    logic              w_out_acc;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [7:0]        w_wdata;
    logic              w_frame_ok;
    logic [7:0]        w_idx_diff;
    t_alu_req          w_alu_req;
    logic [ACC_W-1:0]  w_alu_sum;

    lfd_alu u_alu (
        .i_req (w_alu_req),
        .o_sum (w_alu_sum)
    );

    assign i_in.ready = (r_state == ST_IDLE);
    assign o_out.valid = (r_state == ST_OUT);
    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_out_acc = o_out.valid && o_out.ready;

    assign o_out.angle_deg    = {r_idx, r_reading};
    assign o_out.range_mm     = {r_b1[5:0], r_b0};
    assign o_out.strength     = r_q;
    assign o_out.reading_ok   = (r_b1[7:6] == 2'b00);
    assign o_out.scan_begin   = (r_idx == '0);
    assign o_out.last_reading = (r_reading == 2'd3);

    assign w_idx_diff = r_idx_byte - INDEX_BIAS;
    assign w_frame_ok = (r_chk == {1'b0, r_acc[SUM_W-1:0]})
                        && (r_idx_byte >= INDEX_BIAS) && (r_idx_byte <= INDEX_LAST);

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_pos      = r_pos;
        n_half     = r_half;
        n_reading  = r_reading;
        n_acc      = r_acc;
        n_idx_byte = r_idx_byte;
        n_chk      = r_chk;
        n_idx      = r_idx;
        n_b0       = r_b0;
        n_b1       = r_b1;
        n_q        = r_q;
        n_pending  = r_pending;
        w_we       = 1'b0;
        w_waddr    = r_fill;
        w_wdata    = i_in.rx_byte;
        w_alu_req.op   = r_pos[0] ? ALU_ACC_HI : ALU_ACC_LO;
        w_alu_req.acc  = r_acc;
        w_alu_req.data = r_rd_data;

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_in.rx_byte == START_MARK && r_fill == FULL_COUNT) begin
                        // hold the start byte until the old frame is read out
                        n_pending = i_in.rx_byte;
                        n_pos     = '0;
                        n_half    = 1'b0;
                        n_acc     = '0;
                        n_state   = ST_CHECK;
                    end else if (i_in.rx_byte == START_MARK) begin
                        w_we    = 1'b1;
                        w_waddr = '0;
                        n_fill  = ADDR_W'(1);
                    end else if (r_fill < FULL_COUNT) begin
                        w_we   = 1'b1;
                        n_fill = r_fill + 1'b1;
                    end
                end
            end
            ST_CHECK: begin
                n_half = !r_half;
                if (r_half) begin
                    if (r_pos < CHECK_BASE) begin
                        n_acc = w_alu_sum;
                    end
                    if (r_pos == INDEX_POS) begin
                        n_idx_byte = r_rd_data;
                    end
                    if (r_pos == CHECK_BASE) begin
                        n_chk[7:0] = r_rd_data;
                    end
                    if (r_pos == CHECK_HI) begin
                        n_chk[15:8] = r_rd_data;
                        n_state     = ST_FOLD;
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
            end
            ST_FOLD: begin
                w_alu_req.op = ALU_FOLD;
                n_acc        = w_alu_sum;
                n_state      = ST_VERIFY;
            end
            ST_VERIFY: begin
                n_idx = w_idx_diff[IDX_W-1:0];
                if (w_frame_ok) begin
                    n_pos     = DATA_BASE;
                    n_half    = 1'b0;
                    n_reading = '0;
                    n_state   = ST_LOAD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_LOAD: begin
                n_half = !r_half;
                if (r_half) begin
                    n_pos = r_pos + 1'b1;
                    case (r_pos[1:0])
                        2'd0: n_b0 = r_rd_data;
                        2'd1: n_b1 = r_rd_data;
                        2'd2: n_q[7:0] = r_rd_data;
                        default: begin
                            n_q[15:8] = r_rd_data;
                            n_state   = ST_OUT;
                        end
                    endcase
                end
            end
            ST_OUT: begin
                if (w_out_acc) begin
                    if (r_reading == 2'd3) begin
                        n_state = ST_DONE;
                    end else begin
                        n_reading = r_reading + 1'b1;
                        n_half    = 1'b0;
                        n_state   = ST_LOAD;
                    end
                end
            end
            ST_DONE: begin
                // the start byte opens the next frame
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = r_pending;
                n_fill  = ADDR_W'(1);
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fill    <= '0;
            r_pos     <= '0;
            r_half    <= 1'b0;
            r_reading <= '0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_pos     <= n_pos;
            r_half    <= n_half;
            r_reading <= n_reading;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc      <= n_acc;
        r_idx_byte <= n_idx_byte;
        r_chk      <= n_chk;
        r_idx      <= n_idx;
        r_b0       <= n_b0;
        r_b1       <= n_b1;
        r_q        <= n_q;
        r_pending  <= n_pending;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= mem[r_pos];
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("reading offered while a byte is taken");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_COUNT)
        else $error("fill count beyond frame length");

    a_start_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in.rx_byte == START_MARK && r_fill == FULL_COUNT)
        |=> (r_state == ST_CHECK))
        else $error("full frame not checked on start byte");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_out.last_reading) |=> (r_state == ST_DONE && r_fill == FULL_COUNT))
        else $error("frame not closed after fourth reading");

endmodule

// ===== tb/lfd_reading_checker.sv =====
// Reading checker for the laser frame decoder: tracks accepted bytes, predicts the
// readings of each good frame and compares them with the reading channel.
// Depends on lfd_pkg.
module lfd_reading_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_byte_valid,
    input  logic        i_byte_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_reading_valid,
    input  logic        i_reading_ready,
    input  logic [8:0]  i_angle_deg,
    input  logic [13:0] i_range_mm,
    input  logic [15:0] i_strength,
    input  logic        i_reading_ok,
    input  logic        i_scan_begin,
    input  logic        i_last_reading,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import lfd_pkg::*;

    typedef struct packed {
        logic [8:0]  angle_deg;
        logic [13:0] range_mm;
        logic [15:0] strength;
        logic        reading_ok;
        logic        scan_begin;
        logic        last_reading;
    } t_reading;

    t_reading   readings_due[$];
    logic [7:0] frame_bytes [FRAME_LENGTH];
    int         bytes_held;
    int         mismatches;

    initial begin
        bytes_held   = 0;
        mismatches   = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin : track
        logic [31:0] fold;
        logic [14:0] sum;
        logic [7:0]  idx;
        logic [7:0]  lo;
        logic [7:0]  hi;
        t_reading    got;
        t_reading    want;
        if (!i_rst_n) begin
            bytes_held = 0;
            readings_due.delete();
        end else begin
            if (i_byte_valid && i_byte_ready) begin
                if (i_rx_byte == START_MARK) begin
                    idx = frame_bytes[INDEX_POS] - INDEX_BIAS;
                    if (bytes_held == FRAME_LENGTH && frame_bytes[INDEX_POS] >= INDEX_BIAS &&
                        frame_bytes[INDEX_POS] <= INDEX_LAST) begin
                        fold = '0;
                        for (int k = 0; k < 10; k++)
                            fold = (fold << 1) + {frame_bytes[2*k+1], frame_bytes[2*k]};
                        // end-around fold of the overflow into 15 bits
                        sum = 15'(fold) + 15'(fold >> 15);
                        if ({1'b0, sum} == {frame_bytes[CHECK_HI], frame_bytes[CHECK_BASE]}) begin
                            for (int r = 0; r < 4; r++) begin
                                lo = frame_bytes[DATA_BASE + 4*r];
                                hi = frame_bytes[DATA_BASE + 4*r + 1];
                                want.angle_deg    = 9'(4 * idx + r);
                                want.range_mm     = {hi[5:0], lo};
                                want.strength     = {frame_bytes[DATA_BASE + 4*r + 3],
                                                     frame_bytes[DATA_BASE + 4*r + 2]};
                                want.reading_ok   = (hi[7:6] == 2'b00);
                                want.scan_begin   = (idx == 8'd0);
                                want.last_reading = (r == 3);
                                readings_due.push_back(want);
                            end
                        end
                    end
                    bytes_held = 0;
                end
                // drop bytes past a full frame
                if (bytes_held < FRAME_LENGTH) begin
                    frame_bytes[bytes_held] = i_rx_byte;
                    bytes_held++;
                end
            end

            if (i_reading_valid && i_reading_ready) begin
                got = {i_angle_deg, i_range_mm, i_strength,
                       i_reading_ok, i_scan_begin, i_last_reading};
                if (readings_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected reading angle %0d range %0d strength %0d",
                                 $realtime, i_angle_deg, i_range_mm, i_strength);
                end else begin
                    want = readings_due.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: reading mismatch exp angle %0d range %0d str %0d",
                                      " ok %0b scan %0b last %0b / got %0d %0d %0d %0b %0b %0b"},
                                     $realtime, want.angle_deg, want.range_mm, want.strength,
                                     want.reading_ok, want.scan_begin, want.last_reading,
                                     got.angle_deg, got.range_mm, got.strength,
                                     got.reading_ok, got.scan_begin, got.last_reading);
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= readings_due.size();
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the laser frame decoder: clock, reset, byte stream and reading
// sink with random stalls. Depends on lfd_pkg, lfd_in_if, lfd_out_if,
// lidar_frame_decoder and lfd_reading_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lfd_pkg::*;

    typedef enum {
        FR_GOOD,
        FR_HEADLESS,
        FR_BAD_SUM,
        FR_SHORT,
        FR_LONG
    } t_frame_shape;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   bytes_sent  = 0;
    bit   idle_mode   = 1'b0;
    bit   stall_mode  = 1'b1;
    bit   calm        = 1'b0;

    lfd_in_if  in_ch ();
    lfd_out_if out_ch ();

    lidar_frame_decoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    lfd_reading_checker u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_byte_valid    (in_ch.valid),
        .i_byte_ready    (in_ch.ready),
        .i_rx_byte       (in_ch.rx_byte),
        .i_reading_valid (out_ch.valid),
        .i_reading_ready (out_ch.ready),
        .i_angle_deg     (out_ch.angle_deg),
        .i_range_mm      (out_ch.range_mm),
        .i_strength      (out_ch.strength),
        .i_reading_ok    (out_ch.reading_ok),
        .i_scan_begin    (out_ch.scan_begin),
        .i_last_reading  (out_ch.last_reading),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // payload byte that never looks like a start byte
    function automatic logic [7:0] pick_data();
        logic [7:0] b;
        case ($urandom_range(0, 7))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            default: b = 8'($urandom);
        endcase
        if (b == START_MARK)
            b = b ^ 8'h01;
        return b;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if (idle_mode && !calm && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= b;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        bytes_sent++;
    endtask

    // fill < 0 means random payload, otherwise every payload byte takes that value
    task automatic send_frame(input logic [7:0] idx_byte, input t_frame_shape shape,
                              input int fill);
        logic [7:0]  fb [FRAME_LENGTH];
        logic [31:0] fold;
        logic [15:0] cks;
        int          n;
        idle_mode = ($urandom_range(0, 2) != 0);
        fb[0] = START_MARK;
        if (shape == FR_HEADLESS)
            fb[0] = (fill < 0) ? pick_data() : 8'(fill);
        fb[1] = idx_byte;
        for (int k = 2; k < 20; k++)
            fb[k] = (fill < 0) ? pick_data() : 8'(fill);
        fold = '0;
        for (int k = 0; k < 10; k++)
            fold = (fold << 1) + {fb[2*k+1], fb[2*k]};
        cks = {1'b0, 15'(fold) + 15'(fold >> 15)};
        if (shape == FR_BAD_SUM)
            cks = cks ^ 16'($urandom_range(1, 16'hFFFF));
        fb[20] = cks[7:0];
        fb[21] = cks[15:8];
        n = FRAME_LENGTH;
        if (shape == FR_SHORT)
            n = $urandom_range(1, FRAME_LENGTH - 1);
        for (int k = 0; k < n; k++)
            send_byte(fb[k]);
        if (shape == FR_LONG)
            repeat ($urandom_range(1, 6)) send_byte(pick_data());
    endtask

    initial begin
        logic [7:0] idx;
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.rx_byte <= 8'h00;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // frame with no leading start byte, index 0, all-zero payload
        send_frame(INDEX_BIAS, FR_HEADLESS, 0);
        // last index, all-ones payload: flags set, widest range and strength
        send_frame(INDEX_LAST, FR_GOOD, 8'hFF);
        send_frame(INDEX_BIAS, FR_SHORT, -1);
        // index 90 is the start byte itself
        send_frame(START_MARK, FR_GOOD, -1);
        send_frame(INDEX_BIAS - 8'd1, FR_GOOD, -1);

        while (bytes_sent < 260) begin
            calm = (bytes_sent >= 210);
            case ($urandom_range(0, 3))
                0:       idx = INDEX_BIAS;
                1:       idx = INDEX_LAST;
                default: idx = INDEX_BIAS + 8'($urandom_range(0, 89));
            endcase
            case ($urandom_range(0, 19))
                0: send_frame(idx, FR_BAD_SUM, -1);
                1: send_frame(idx, FR_SHORT, -1);
                2: send_frame(idx, FR_LONG, -1);
                3: begin
                    idx = $urandom_range(0, 1) ? 8'($urandom_range(0, 8'h9F))
                                               : 8'($urandom_range(8'hFB, 8'hFF));
                    send_frame(idx, FR_GOOD, -1);
                end
                4: repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
                default: send_frame(idx, FR_GOOD, -1);
            endcase
        end
        calm = 1'b1;
        // close the last frame
        send_byte(START_MARK);
        in_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial begin
        out_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1)
            @(posedge i_clk);
        forever begin
            if (stall_mode && !calm && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            if ($urandom_range(0, 39) == 0)
                stall_mode = !stall_mode;
        end
    end

    initial begin
        #2_000_000;
        $display("tb failed");
        $finish;
    end

endmodule

// ===== lidar_frame_decoder.f =====
hdl/lfd_pkg.sv
hdl/lfd_in_if.sv
hdl/lfd_out_if.sv
hdl/lfd_alu.sv
hdl/lidar_frame_decoder.sv
tb/lfd_reading_checker.sv
tb/tb.sv
